/* rtl/core/ccs_pkg.sv */
// Shared types, constants and helpers for the clause conflict scorer.
// No dependencies; imported by ccs_div and clause_conflict_score.

package ccs_pkg;

    localparam int STAB_W     = 17;
    localparam int SCORE_W    = 32;
    localparam int LIT_CNT_W  = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int MUL_W      = 28;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_STEP_W = 5;

    localparam logic [STAB_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [MUL_W-1:0]  RECIP_100   = 28'd171798692;
    localparam int                RECIP_SHIFT = 34;

    localparam logic [2:0] MODE_AVG   = 3'd0;
    localparam logic [2:0] MODE_LUKA  = 3'd1;
    localparam logic [2:0] MODE_PROD  = 3'd2;
    localparam logic [2:0] MODE_MIN   = 3'd3;
    localparam logic [2:0] MODE_MIN2  = 3'd4;
    localparam logic [2:0] MODE_UNST  = 3'd5;
    localparam logic [2:0] MODE_GEN   = 3'd6;
    localparam logic [2:0] MODE_SUM   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALSE_THR  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRUE_THR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRUE_PEN   = 4'd3;

    typedef struct packed {
        logic [STAB_W-1:0] true_stab;
        logic [STAB_W-1:0] false_stab;
        logic              lit_negative;
        logic              last_lit;
    } t_lit_in;

    typedef struct packed {
        logic [SCORE_W-1:0]   score;
        logic [LIT_CNT_W-1:0] lit_count;
    } t_score_out;

    function automatic logic [STAB_W-1:0] f_clamp_one(input logic [STAB_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [SCORE_W-1:0] f_accum_start(input logic [2:0] mode);
        logic start_one;
        start_one = (mode == MODE_LUKA) || (mode == MODE_PROD) ||
                    (mode == MODE_MIN) || (mode == MODE_MIN2);
        return start_one ? SCORE_W'(ONE_Q16) : '0;
    endfunction

endpackage

/* rtl/core/clause_conflict_score.sv */
// Clause conflict scorer: streams literals, accumulates one of eight clause scores.
// Depends on ccs_pkg and ccs_div.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_in_data    | literal beat in
//   out     | o_out_valid, i_out_ready, o_out_data | score beat out
//   cfg     | i_cfg_valid, o_cfg_ready, i_cfg_*    | register write in
//
// A literal goes through accept, two passes through the shared multiplier, and update.
// A last literal then passes through the output-load state; in average mode it first
// waits in the divide state for the radix-2 divider (one quotient bit per cycle).
// Reset is synchronous and restores the state, configuration and clause registers; no clearing pass.
// A result waiting in the output register holds the next last literal in the load
// state, and intake stays closed until the waiting beat leaves.

module clause_conflict_score
    import ccs_pkg::*;
#(
    parameter int MAX_CLAUSE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_lit_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_score_out            o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int            CW      = $clog2(MAX_CLAUSE + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLAUSE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_UPD,
        S_DIV,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_mode;
    logic [6:0]         r_false_thr;
    logic [6:0]         r_true_thr;
    logic [9:0]         r_pen;
    logic [SCORE_W-1:0] r_accum;
    logic [STAB_W-1:0]  r_smin;
    logic [CW-1:0]      r_count;
    logic [STAB_W-1:0]  r_pf;
    logic [STAB_W-1:0]  r_pt;
    logic [STAB_W-1:0]  r_unass;
    logic               r_st_false;
    logic               r_st_true;
    logic               r_last;
    logic [PROD_W-1:0]  r_prod;
    logic [SCORE_W-1:0] r_res;
    logic [CW-1:0]      r_res_cnt;
    logic               r_out_vld;
    t_score_out         r_out;

    logic [STAB_W-1:0]  ts;
    logic [STAB_W-1:0]  fs;
    logic [STAB_W-1:0]  pf;
    logic [STAB_W-1:0]  pt;
    logic [STAB_W:0]    stab_sum;
    logic [23:0]        pf_x100;
    logic [23:0]        pt_x100;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [SCORE_W:0]   accum_pf;
    logic [SCORE_W:0]   addend;
    logic [SCORE_W:0]   sat_sum;
    logic [SCORE_W-1:0] cnt_diff;
    logic [SCORE_W-1:0] n_accum;
    logic [STAB_W-1:0]  n_smin;
    logic [CW-1:0]      n_count;
    logic [SCORE_W-1:0] n_score;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [SCORE_W-1:0] div_quo;
    logic               cfg_wr;
    logic [2:0]         cfg_mode;

    assign ts       = f_clamp_one(i_in_data.true_stab);
    assign fs       = f_clamp_one(i_in_data.false_stab);
    assign pf       = i_in_data.lit_negative ? ts : fs;
    assign pt       = i_in_data.lit_negative ? fs : ts;
    assign stab_sum = {1'b0, ts} + {1'b0, fs};
    assign pf_x100  = 24'(pf) * 24'd100;
    assign pt_x100  = 24'(pt) * 24'd100;

    // shared multiplier: product, penalty scaling and reciprocal of 100
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL1) begin
            case (r_mode)
                MODE_PROD: begin
                    mul_a = MUL_W'(r_accum[STAB_W-1:0]);
                    mul_b = MUL_W'(r_pf);
                end
                MODE_GEN: begin
                    mul_a = MUL_W'({r_pen, 16'b0});
                    mul_b = RECIP_100;
                end
                MODE_SUM: begin
                    mul_a = MUL_W'(r_pt);
                    mul_b = MUL_W'(r_pen);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            mul_a = r_prod[MUL_W-1:0];
            mul_b = RECIP_100;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign accum_pf = {1'b0, r_accum} + (SCORE_W + 1)'(r_pf);

    always_comb begin
        case (r_mode)
            MODE_GEN: addend = r_st_true ? (SCORE_W + 1)'(r_prod[PROD_W-1:RECIP_SHIFT])
                                         : (SCORE_W + 1)'(ONE_Q16);
            default:  addend = (SCORE_W + 1)'(r_unass)
                               + (SCORE_W + 1)'(r_prod[PROD_W-1:RECIP_SHIFT]);
        endcase
    end

    assign sat_sum = {1'b0, r_accum} + addend;

    always_comb begin
        n_accum = r_accum;
        n_smin  = r_smin;
        n_count = r_count;
        if (r_count < MAX_CNT) begin
            n_count = r_count + CW'(1);
            case (r_mode)
                MODE_AVG:  n_accum = accum_pf[SCORE_W-1:0];
                MODE_LUKA: n_accum = (accum_pf > (SCORE_W + 1)'(ONE_Q16))
                                     ? SCORE_W'(accum_pf - (SCORE_W + 1)'(ONE_Q16)) : '0;
                MODE_PROD: n_accum = SCORE_W'(r_prod[47:16]);
                MODE_MIN: begin
                    if (SCORE_W'(r_pf) < r_accum) n_accum = SCORE_W'(r_pf);
                end
                MODE_MIN2: begin
                    if (SCORE_W'(r_pf) < r_accum) begin
                        n_smin  = r_accum[STAB_W-1:0];
                        n_accum = SCORE_W'(r_pf);
                    end else if (r_pf < r_smin) begin
                        n_smin = r_pf;
                    end
                end
                MODE_UNST: begin
                    if (r_st_false) n_accum = r_accum + SCORE_W'(1);
                end
                MODE_GEN: begin
                    if (!r_st_false) n_accum = sat_sum[SCORE_W] ? '1 : sat_sum[SCORE_W-1:0];
                end
                default:   n_accum = sat_sum[SCORE_W] ? '1 : sat_sum[SCORE_W-1:0];
            endcase
        end
    end

    assign cnt_diff = SCORE_W'(n_count) - n_accum;

    always_comb begin
        case (r_mode)
            MODE_MIN2: n_score = SCORE_W'(n_smin);
            MODE_UNST: n_score = {cnt_diff[15:0], 16'b0};
            default:   n_score = n_accum;
        endcase
    end

    assign out_free  = !r_out_vld || i_out_ready;
    assign div_start = (r_state == S_UPD) && r_last && (r_mode == MODE_AVG);
    assign cfg_wr    = i_cfg_valid && (i_cfg_index <= REG_TRUE_PEN);
    assign cfg_mode  = (i_cfg_index == REG_SCORE_MODE) ? i_cfg_data[2:0] : r_mode;

    ccs_div #(
        .DW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_accum),
        .i_divisor  (n_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_AVG;
            r_false_thr <= 7'd50;
            r_true_thr  <= 7'd50;
            r_pen       <= 10'd100;
            r_accum     <= f_accum_start(MODE_AVG);
            r_smin      <= ONE_Q16;
            r_count     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_last) begin
                        r_state <= (r_mode == MODE_AVG) ? S_DIV : S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_wr) begin
                r_accum <= f_accum_start(cfg_mode);
                r_smin  <= ONE_Q16;
                r_count <= '0;
            end else if (r_state == S_UPD) begin
                if (r_last) begin
                    r_accum <= f_accum_start(r_mode);
                    r_smin  <= ONE_Q16;
                    r_count <= '0;
                end else begin
                    r_accum <= n_accum;
                    r_smin  <= n_smin;
                    r_count <= n_count;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SCORE_MODE: begin
                        r_mode <= i_cfg_data[2:0];
                    end
                    REG_FALSE_THR: begin
                        r_false_thr <= i_cfg_data[6:0];
                    end
                    REG_TRUE_THR: begin
                        r_true_thr <= i_cfg_data[6:0];
                    end
                    REG_TRUE_PEN: begin
                        r_pen <= i_cfg_data;
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_pf       <= pf;
            r_pt       <= pt;
            r_unass    <= (stab_sum >= (STAB_W + 1)'(ONE_Q16))
                          ? '0 : STAB_W'((STAB_W + 1)'(ONE_Q16) - stab_sum);
            r_st_false <= pf_x100 > {1'b0, r_false_thr, 16'b0};
            r_st_true  <= pt_x100 > {1'b0, r_true_thr, 16'b0};
            r_last     <= i_in_data.last_lit;
        end
        if (r_state == S_MUL1 || (r_state == S_MUL2 && r_mode == MODE_SUM)) begin
            r_prod <= mul_p;
        end
        if (r_state == S_UPD && r_last) begin
            r_res     <= n_score;
            r_res_cnt <= n_count;
        end else if (r_state == S_DIV && div_done) begin
            r_res <= div_quo;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.score     <= r_res;
            r_out.lit_count <= LIT_CNT_W'(r_res_cnt);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("clause count above limit");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output load");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_last) |=> !o_in_ready)
        else $error("intake open while result pending");

endmodule

/* rtl/core/ccs_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, for the clause average.
// Depends on ccs_pkg.

module ccs_div
    import ccs_pkg::*;
#(
    parameter int DW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SCORE_W-1:0] i_dividend,
    input  logic [DW-1:0]      i_divisor,
    output logic               o_done,
    output logic [SCORE_W-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [DW-1:0]         r_rem;
    logic [DW-1:0]         r_dsr;
    logic [SCORE_W-1:0]    r_quo;
    logic [DW:0]           rem_sh;
    logic                  take;

    assign rem_sh = {r_rem, r_quo[SCORE_W-1]};
    assign take   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + DIV_STEP_W'(1);
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= take ? DW'(rem_sh - {1'b0, r_dsr}) : DW'(rem_sh);
            r_quo <= {r_quo[SCORE_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* tb/clause_conflict_score_chk.sv */
// Scoreboard for clause_conflict_score: watches the literal, score and register channels,
// tracks the scorer state and compares every score beat with the predicted one.
// Depends on ccs_pkg.

module clause_conflict_score_chk
    import ccs_pkg::*;
#(
    parameter int MAX_CLAUSE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_lit_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_score_out            i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    logic [2:0]         clause_mode = MODE_AVG;
    logic [6:0]         false_thr   = 7'd50;
    logic [6:0]         true_thr    = 7'd50;
    logic [9:0]         true_pen    = 10'd100;
    logic [SCORE_W-1:0] clause_acc  = '0;
    logic [STAB_W-1:0]  runner_up   = ONE_Q16;
    int                 lit_cnt     = 0;
    t_score_out         pending_scores[$];
    int                 mismatch_count = 0;
    int                 pending_now    = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_now;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [SCORE_W-1:0] add_sat(input logic [SCORE_W-1:0] a,
                                                   input logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > 64'hFFFF_FFFF) ? '1 : s[SCORE_W-1:0];
    endfunction

    task automatic restart_clause();
        clause_acc = (clause_mode >= MODE_LUKA && clause_mode <= MODE_MIN2) ?
                     SCORE_W'(ONE_Q16) : '0;
        runner_up  = ONE_Q16;
        lit_cnt    = 0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SCORE_MODE: begin
                clause_mode = data[2:0];
                restart_clause();
            end
            REG_FALSE_THR: begin
                false_thr = data[6:0];
                restart_clause();
            end
            REG_TRUE_THR: begin
                true_thr = data[6:0];
                restart_clause();
            end
            REG_TRUE_PEN: begin
                true_pen = data[9:0];
                restart_clause();
            end
            default: begin
            end
        endcase
    endtask

    task automatic score_literal(input t_lit_in lit);
        logic [STAB_W-1:0] ts, fs, pf, pt, unass;
        logic [STAB_W:0]   both;
        logic              st_false, st_true;
        logic [63:0]       s, sc;
        t_score_out        want;
        ts = (lit.true_stab > ONE_Q16) ? ONE_Q16 : lit.true_stab;
        fs = (lit.false_stab > ONE_Q16) ? ONE_Q16 : lit.false_stab;
        pf = lit.lit_negative ? ts : fs;
        pt = lit.lit_negative ? fs : ts;
        st_false = 64'(pf) * 64'd100 > 64'(false_thr) * 64'd65536;
        st_true  = 64'(pt) * 64'd100 > 64'(true_thr) * 64'd65536;
        if (lit_cnt < MAX_CLAUSE) begin
            lit_cnt++;
            case (clause_mode)
                MODE_AVG: clause_acc = clause_acc + SCORE_W'(pf);
                MODE_LUKA: begin
                    s = 64'(clause_acc) + 64'(pf);
                    clause_acc = (s > 64'(ONE_Q16)) ? SCORE_W'(s - 64'(ONE_Q16)) : '0;
                end
                MODE_PROD: clause_acc = SCORE_W'((64'(clause_acc) * 64'(pf)) >> 16);
                MODE_MIN: begin
                    if (SCORE_W'(pf) < clause_acc) clause_acc = SCORE_W'(pf);
                end
                MODE_MIN2: begin
                    if (SCORE_W'(pf) < clause_acc) begin
                        runner_up  = clause_acc[STAB_W-1:0];
                        clause_acc = SCORE_W'(pf);
                    end else if (pf < runner_up) begin
                        runner_up = pf;
                    end
                end
                MODE_UNST: begin
                    if (st_false) clause_acc = clause_acc + SCORE_W'(1);
                end
                MODE_GEN: begin
                    if (st_false) begin
                    end else if (st_true) begin
                        clause_acc = add_sat(clause_acc, (64'(true_pen) << 16) / 100);
                    end else begin
                        clause_acc = add_sat(clause_acc, 64'(ONE_Q16));
                    end
                end
                default: begin
                    both  = {1'b0, ts} + {1'b0, fs};
                    unass = (both >= ONE_Q16) ? '0 : STAB_W'(ONE_Q16 - both);
                    clause_acc = add_sat(clause_acc,
                                         64'(unass) + (64'(pt) * 64'(true_pen)) / 100);
                end
            endcase
        end
        if (lit.last_lit) begin
            case (clause_mode)
                MODE_AVG:  sc = (lit_cnt != 0) ? 64'(clause_acc / 32'(lit_cnt)) : '0;
                MODE_MIN2: sc = 64'(runner_up);
                MODE_UNST: sc = 64'(32'(lit_cnt) - clause_acc) << 16;
                default:   sc = 64'(clause_acc);
            endcase
            if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
            want.score     = sc[SCORE_W-1:0];
            want.lit_count = LIT_CNT_W'(lit_cnt);
            pending_scores.push_back(want);
            restart_clause();
        end
    endtask

    task automatic check_beat(input t_score_out got);
        t_score_out want;
        if (pending_scores.size() == 0) begin
            flag_mismatch("score beat with nothing pending", 64'(got.score), '0);
        end else begin
            want = pending_scores.pop_front();
            if (got.score !== want.score)
                flag_mismatch("score", 64'(got.score), 64'(want.score));
            if (got.lit_count !== want.lit_count)
                flag_mismatch("lit_count", 64'(got.lit_count), 64'(want.lit_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clause_mode = MODE_AVG;
            false_thr   = 7'd50;
            true_thr    = 7'd50;
            true_pen    = 10'd100;
            restart_clause();
            pending_scores.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) score_literal(i_in_data);
            if (i_out_valid && i_out_ready) check_beat(i_out_data);
        end
        pending_now = pending_scores.size();
    end

endmodule

/* tb/clause_conflict_score_tb.sv */
// Top of the clause_conflict_score testbench: clock, reset, literal and register stimulus,
// random output back-pressure and the final verdict.
// Depends on ccs_pkg, clause_conflict_score and clause_conflict_score_chk.

module clause_conflict_score_tb;
    import ccs_pkg::*;

    localparam int CLAUSE_CAP    = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 16;
    localparam int SEG_ITEMS     = 70;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_lit_in               in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready, out_valid, cfg_ready;
    t_score_out            out_data;

    int         mismatches, pending;
    int         cycles        = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req      = 1'b0;
    bit         hold_done     = 1'b0;
    logic [6:0] cur_false_thr = 7'd50;
    logic [6:0] cur_true_thr  = 7'd50;

    clause_conflict_score #(.MAX_CLAUSE(CLAUSE_CAP)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    clause_conflict_score_chk #(.MAX_CLAUSE(CLAUSE_CAP)) chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // score sink: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_lit_in lit_of(input logic [STAB_W-1:0] ts,
                                       input logic [STAB_W-1:0] fs,
                                       input logic neg, input logic last);
        t_lit_in lit;
        lit.true_stab    = ts;
        lit.false_stab   = fs;
        lit.lit_negative = neg;
        lit.last_lit     = last;
        return lit;
    endfunction

    function automatic logic [STAB_W-1:0] pick_stab();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return ONE_Q16;
        if (r < 30) return STAB_W'($urandom_range(131071));
        if (r < 45) begin
            v = ($urandom_range(1) ? int'(cur_false_thr) : int'(cur_true_thr)) * 65536 / 100;
            v = v + int'($urandom_range(2)) - 1;
            if (v < 0) v = 0;
            return STAB_W'(v);
        end
        return STAB_W'($urandom_range(65536));
    endfunction

    task automatic offer_lit(input t_lit_in lit);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= lit;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic offer_clause(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            offer_lit(lit_of(pick_stab(), pick_stab(), 1'($urandom_range(1)),
                             closed && (i == len - 1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid and drain every pending score, then idle before the next step
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure_segment(input int seg);
        logic [2:0] mode;
        logic [2:0] pad;
        logic [9:0] pen;
        mode = 3'(seg % 8);
        pad  = (seg % 4 == 3) ? 3'($urandom_range(7)) : 3'b0;
        case (seg % 4)
            0: begin
                cur_false_thr = 7'd0;
                cur_true_thr  = 7'd100;
            end
            1: begin
                cur_false_thr = 7'd100;
                cur_true_thr  = 7'd127;
            end
            2: begin
                cur_false_thr = 7'd127;
                cur_true_thr  = 7'd0;
            end
            default: begin
                cur_false_thr = 7'($urandom_range(127));
                cur_true_thr  = 7'($urandom_range(127));
            end
        endcase
        case (seg % 3)
            0: pen = 10'd0;
            1: pen = 10'd1023;
            default: pen = 10'($urandom_range(1023));
        endcase
        write_reg(REG_SCORE_MODE, {7'($urandom_range(127)), mode});
        write_reg(REG_FALSE_THR, {pad, cur_false_thr});
        write_reg(REG_TRUE_THR, {pad, cur_true_thr});
        write_reg(REG_TRUE_PEN, pen);
    endtask

    initial begin
        int n;
        int r;
        int len;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 37;
        recv_idle_pct = 60;

        // one short clause per mode with extreme and boundary stabilities
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_SCORE_MODE, CFG_DATA_W'(m));
            offer_lit(lit_of('0, ONE_Q16, 1'b0, 1'b0));
            offer_lit(lit_of(17'h1FFFF, '0, 1'b1, 1'b0));
            offer_lit(lit_of(17'd16000, 17'd32768, 1'b0, 1'b1));
            settle();
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 6) begin
                send_idle_pct = 60;
                recv_idle_pct = 37;
            end else if (seg == 11) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure_segment(seg);
            n = 0;
            if (seg == 2) begin
                hold_req = 1'b1;
                for (int i = 0; i < 60; i++) offer_clause(1, 1'b1);
                n = 60;
            end
            if (seg % 3 == 1) begin
                // partial clause must survive a write to an unused index
                offer_clause(2, 1'b0);
                settle();
                write_reg(CFG_IDX_W'($urandom_range({CFG_IDX_W{1'b1}}, REG_SPARE_FIRST)),
                          CFG_DATA_W'($urandom_range(1023)));
                n += 2;
            end
            while (n < SEG_ITEMS) begin
                r = $urandom_range(99);
                if (r < 3)
                    len = $urandom_range(72, 65);
                else if (r < 20)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(8, 1);
                offer_clause(len, 1'b1);
                n += len;
            end
            // leave a clause open so the next register write abandons it
            if (seg % 2 == 1) offer_clause($urandom_range(4, 1), 1'b0);
            settle();
        end

        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
